### design/hbrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hbrf_pkg;

    // Geometry
    localparam int NUM_AXES   = 3;
    localparam int CRD_W      = 32;             // coordinate, signed
    localparam int DIF_W      = CRD_W + 1;      // separation component, signed
    localparam int MAG_W      = CRD_W;          // |separation component|
    localparam int SQ_W       = 2 * MAG_W;      // square of one component
    localparam int SUM_W      = SQ_W + 2;       // sum of three squares
    localparam int LEN_W      = SUM_W / 2;      // bond length

    // Rail vector
    localparam int RAIL_W     = 18;             // signed Q1.16
    localparam int RAIL_FRAC  = 16;

    // Projection p = s . u
    localparam int PRD_W      = DIF_W + RAIL_W; // one signed product
    localparam int P_W        = 52;             // signed sum of three products
    localparam int PMAG_W     = P_W - 1;        // |p|

    // Configuration
    localparam int K_W        = 32;
    localparam int R0_W       = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Length error e = L - r0
    localparam int ERR_W      = LEN_W + 1;
    localparam int EMAG_W     = LEN_W;

    // Energy path
    localparam int Q_W        = PMAG_W - RAIL_FRAC;   // |p| >> 16
    localparam int D_W        = Q_W + 2;              // signed q - r0
    localparam int DMAG_W     = D_W - 1;
    localparam int D2_W       = 2 * DMAG_W;
    localparam int KD_W       = K_W + DMAG_W;
    localparam int T_W        = K_W + D2_W;
    localparam int EN_W       = 48;

    // Force path
    localparam int LO_W       = 32;             // low slice of split multiplies
    localparam int CAP_W      = 64;             // intermediate clamp point
    localparam int HC_W       = CAP_W - RAIL_FRAC + 1;
    localparam int FP_W       = HC_W + RAIL_W;
    localparam int FM_W       = FP_W - RAIL_FRAC;
    localparam int FRC_W      = 32;

    localparam logic [FRC_W-1:0] FRC_POS_CAP = 32'h7FFF_FFFF;
    localparam logic [FRC_W-1:0] FRC_NEG_CAP = 32'h8000_0000;

    // Register reset values
    localparam logic [K_W-1:0]    K_RESET      = 32'h0001_0000;
    localparam logic [R0_W-1:0]   R0_RESET     = 32'h0001_0000;
    localparam logic [RAIL_W-1:0] RAIL_X_RESET = 18'h1_0000;
    localparam logic [RAIL_W-1:0] RAIL_Y_RESET = 18'h0_0000;
    localparam logic [RAIL_W-1:0] RAIL_Z_RESET = 18'h0_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPRING = 3'd0,
        CFG_REST   = 3'd1,
        CFG_RAIL_X = 3'd2,
        CFG_RAIL_Y = 3'd3,
        CFG_RAIL_Z = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [K_W-1:0]                   k;
        logic [R0_W-1:0]                  r0;
        logic [NUM_AXES-1:0][RAIL_W-1:0]  rail;
    } t_cfg;

endpackage

`default_nettype wire

### design/harmonic_bond_rail_force.sv
`timescale 1ns / 1ps
`default_nettype none

// Harmonic bond force and energy, projected onto a loaded rail vector.
// Input channel (i_valid / o_stall): one word per bond, the two atom positions.
// Output channel (o_valid / i_stall): force on the first atom, energy and flags.
// Config channel (i_cfg_valid / o_cfg_ready): k, r0 and the rail, written by
// index; the user writes them only while the pipeline is empty, which the
// block does not enforce. o_cfg_ready is always high. Throughput: one word
// per cycle unless an output word is held. Words pass the 33-stage square root
// and the 51-stage divider (one result bit per stage each) plus 14 arithmetic stages.
// All stages advance together; when the output word is held by i_stall the
// whole pipeline freezes and o_stall rises in the same cycle, so nothing is
// dropped or repeated. While o_valid is low the block never stalls.
// Synchronous reset clears every valid bit and loads the register defaults
// (k = 1.0, r0 = 1.0, rail = +x); no clearing pass is needed.
// Coincident atoms give a zero force and raise o_coincident; o_saturated
// marks a clipped force component or energy.

module harmonic_bond_rail_force import hbrf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [CRD_W-1:0]      i_first_x,
    input  logic [CRD_W-1:0]      i_first_y,
    input  logic [CRD_W-1:0]      i_first_z,
    input  logic [CRD_W-1:0]      i_second_x,
    input  logic [CRD_W-1:0]      i_second_y,
    input  logic [CRD_W-1:0]      i_second_z,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [FRC_W-1:0]      o_force_x,
    output logic [FRC_W-1:0]      o_force_y,
    output logic [FRC_W-1:0]      o_force_z,
    output logic [EN_W-1:0]       o_bond_energy,
    output logic                  o_coincident,
    output logic                  o_saturated,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int KP_W   = K_W + EMAG_W;
    localparam int G_W    = KP_W - FRAC_BITS;
    localparam int GH_W   = G_W - LO_W;
    localparam int CH_W   = PMAG_W - LO_W;
    localparam int LL_W   = 2 * LO_W;
    localparam int LH_W   = LO_W + CH_W;
    localparam int HL_W   = GH_W + LO_W;
    localparam int HH_W   = GH_W + CH_W;
    localparam int MID_W  = ((LH_W > HL_W) ? LH_W : HL_W) + 1;
    localparam int ACC_W  = MID_W + LO_W + 1;
    localparam int E_LSB  = 2 * FRAC_BITS + 1;
    localparam int SQ_SW  = P_W + EN_W + 1;
    localparam int DV_SW  = G_W + 3 + EN_W + 1;

    t_cfg w_cfg;
    logic w_adv;

    logic signed [CRD_W-1:0]  w_a    [NUM_AXES];
    logic signed [CRD_W-1:0]  w_b    [NUM_AXES];
    logic signed [RAIL_W-1:0] w_u    [NUM_AXES];
    logic [RAIL_W-1:0]        w_umag [NUM_AXES];
    logic [MAG_W-1:0]         w_smag [NUM_AXES];

    // stage registers
    logic                     r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;
    logic                     r8_v, r9_v, r10_v, r11_v, r12_v, r13_v, r14_v;
    logic signed [DIF_W-1:0]  r1_s  [NUM_AXES];
    logic [SQ_W-1:0]          r2_sq [NUM_AXES];
    logic signed [PRD_W-1:0]  r2_pr [NUM_AXES];
    logic [SUM_W-1:0]         r3_sum, r4_sum, r5_sum, r6_sum, r7_sum;
    logic signed [P_W-1:0]    r3_p, r4_p, r5_p, r6_p, r7_p;
    logic [DMAG_W-1:0]        r4_dmag;
    logic [D2_W-1:0]          r5_d2;
    logic [KD_W-1:0]          r6_klo, r6_khi;
    logic [EN_W-1:0]          r7_energy;
    logic                     r7_esat;

    // energy stage
    logic                     w_pneg4;
    logic [PMAG_W-1:0]        w_pmag4;
    logic [D_W-1:0]           w_q, w_qs, w_d;
    logic [T_W-1:0]           w_t;
    logic                     w_esat7;

    // square root
    logic [SQ_SW-1:0]         w_sq_side_in, w_sq_side_out;
    logic                     w_sq_v;
    logic [LEN_W-1:0]         w_len;
    logic [P_W-1:0]           w_sq_p;
    logic [EN_W-1:0]          w_sq_energy;
    logic                     w_sq_esat;
    logic [ERR_W-1:0]         w_e;

    logic [LEN_W-1:0]         r8_len, r9_len;
    logic [P_W-1:0]           r8_p;
    logic [EN_W-1:0]          r8_energy, r9_energy;
    logic                     r8_esat, r9_esat, r8_eneg, r9_eneg, r8_coinc, r9_coinc;
    logic [EMAG_W-1:0]        r8_emag;
    logic [KP_W-1:0]          r9_kprod;
    logic [PMAG_W-1:0]        r9_pmag;
    logic                     r9_pneg;

    // divider
    logic [DV_SW-1:0]         w_dv_side_in, w_dv_side_out;
    logic                     w_dv_v;
    logic [PMAG_W-1:0]        w_quo;
    logic [G_W-1:0]           w_g;
    logic                     w_dv_eneg, w_dv_pneg, w_dv_coinc, w_dv_esat;
    logic [EN_W-1:0]          w_dv_energy;

    // force tail
    logic [LL_W-1:0]          r10_ll, r11_ll;
    logic [LH_W-1:0]          r10_lh;
    logic [HL_W-1:0]          r10_hl;
    logic [HH_W-1:0]          r10_hh, r11_hh;
    logic [MID_W-1:0]         r11_mid;
    logic [ACC_W-1:0]         w_acc;
    logic                     w_big;
    logic [HC_W-1:0]          r12_hc;
    logic [FP_W-1:0]          r13_fp [NUM_AXES];
    logic                     r10_eneg, r11_eneg, r12_eneg, r13_eneg;
    logic                     r10_cneg, r11_cneg, r12_cneg, r13_cneg;
    logic                     r10_coinc, r11_coinc, r12_coinc, r13_coinc, r14_coinc;
    logic                     r10_esat, r11_esat, r12_esat, r13_esat;
    logic [EN_W-1:0]          r10_energy, r11_energy, r12_energy, r13_energy, r14_energy;

    logic                     w_neg  [NUM_AXES];
    logic [FM_W-1:0]          w_fmag [NUM_AXES];
    logic                     w_over [NUM_AXES];
    logic [FRC_W-1:0]         w_frc  [NUM_AXES];
    logic                     w_fsat;
    logic [FRC_W-1:0]         r14_force [NUM_AXES];
    logic                     r14_sat;

    hbrf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // whole pipeline moves unless the output word is held
    assign w_adv   = !(r14_v && i_stall);
    assign o_stall = !w_adv;

    assign w_a[0] = i_first_x;
    assign w_a[1] = i_first_y;
    assign w_a[2] = i_first_z;
    assign w_b[0] = i_second_x;
    assign w_b[1] = i_second_y;
    assign w_b[2] = i_second_z;

    // rail components and magnitudes, separation magnitudes
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            w_u[i]    = $signed(w_cfg.rail[i]);
            w_umag[i] = w_u[i][RAIL_W-1] ? RAIL_W'(-w_u[i]) : RAIL_W'(w_u[i]);
            w_smag[i] = r1_s[i][DIF_W-1] ? MAG_W'(-r1_s[i]) : MAG_W'(r1_s[i]);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r12_v <= 1'b0;
            r13_v <= 1'b0;
            r14_v <= 1'b0;
        end else if (w_adv) begin
            r1_v  <= i_valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r5_v  <= r4_v;
            r6_v  <= r5_v;
            r7_v  <= r6_v;
            r8_v  <= w_sq_v;
            r9_v  <= r8_v;
            r10_v <= w_dv_v;
            r11_v <= r10_v;
            r12_v <= r11_v;
            r13_v <= r12_v;
            r14_v <= r13_v;
        end
    end

    // stages 1-3: separation, squares and rail products, sums
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r1_s[i]  <= DIF_W'(w_a[i]) - DIF_W'(w_b[i]);
                r2_sq[i] <= SQ_W'(w_smag[i]) * SQ_W'(w_smag[i]);
                r2_pr[i] <= PRD_W'(r1_s[i]) * PRD_W'(w_u[i]);
            end
            r3_sum <= SUM_W'(r2_sq[0]) + SUM_W'(r2_sq[1]) + SUM_W'(r2_sq[2]);
            r3_p   <= P_W'(r2_pr[0]) + P_W'(r2_pr[1]) + P_W'(r2_pr[2]);
        end
    end

    // energy: d = trunc(p / 2^16) - r0
    always_comb begin
        w_pneg4 = r3_p[P_W-1];
        w_pmag4 = w_pneg4 ? PMAG_W'(-r3_p) : PMAG_W'(r3_p);
        w_q     = D_W'(w_pmag4[PMAG_W-1:RAIL_FRAC]);
        w_qs    = w_pneg4 ? (D_W'(0) - w_q) : w_q;
        w_d     = w_qs - D_W'(w_cfg.r0);
    end

    // energy: k * d^2 >> (2F+1), clipped to 48 bits
    assign w_t     = T_W'(r6_klo) + (T_W'(r6_khi) << DMAG_W);
    assign w_esat7 = |w_t[T_W-1:E_LSB+EN_W];

    // stages 4-7: energy, radicand and projection ride along
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_sum    <= r3_sum;
            r4_p      <= r3_p;
            r4_dmag   <= w_d[D_W-1] ? DMAG_W'(D_W'(0) - w_d) : DMAG_W'(w_d);
            r5_sum    <= r4_sum;
            r5_p      <= r4_p;
            r5_d2     <= D2_W'(r4_dmag) * D2_W'(r4_dmag);
            r6_sum    <= r5_sum;
            r6_p      <= r5_p;
            r6_klo    <= KD_W'(w_cfg.k) * KD_W'(r5_d2[DMAG_W-1:0]);
            r6_khi    <= KD_W'(w_cfg.k) * KD_W'(r5_d2[D2_W-1:DMAG_W]);
            r7_sum    <= r6_sum;
            r7_p      <= r6_p;
            r7_esat   <= w_esat7;
            r7_energy <= w_esat7 ? {EN_W{1'b1}} : w_t[E_LSB+EN_W-1:E_LSB];
        end
    end

    // bond length
    assign w_sq_side_in = {r7_p, r7_energy, r7_esat};

    hbrf_sqrt #(
        .NW (SUM_W),
        .RW (LEN_W),
        .SW (SQ_SW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r7_v),
        .i_rad   (r7_sum),
        .i_side  (w_sq_side_in),
        .o_valid (w_sq_v),
        .o_root  (w_len),
        .o_side  (w_sq_side_out)
    );

    assign {w_sq_p, w_sq_energy, w_sq_esat} = w_sq_side_out;
    assign w_e = ERR_W'(w_len) - ERR_W'(w_cfg.r0);

    // stages 8-9: length error, k*|e|, |p|
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_len    <= w_len;
            r8_p      <= w_sq_p;
            r8_energy <= w_sq_energy;
            r8_esat   <= w_sq_esat;
            r8_eneg   <= w_e[ERR_W-1];
            r8_emag   <= w_e[ERR_W-1] ? EMAG_W'(ERR_W'(0) - w_e) : EMAG_W'(w_e);
            r8_coinc  <= (w_len == '0);
            r9_len    <= r8_len;
            r9_kprod  <= KP_W'(w_cfg.k) * KP_W'(r8_emag);
            r9_pneg   <= r8_p[P_W-1];
            r9_pmag   <= r8_p[P_W-1] ? PMAG_W'(P_W'(0) - r8_p) : PMAG_W'(r8_p);
            r9_eneg   <= r8_eneg;
            r9_coinc  <= r8_coinc;
            r9_energy <= r8_energy;
            r9_esat   <= r8_esat;
        end
    end

    // c = |p| / L
    assign w_dv_side_in = {r9_kprod[KP_W-1:FRAC_BITS], r9_eneg, r9_pneg, r9_coinc,
                           r9_energy, r9_esat};

    hbrf_div #(
        .NW (PMAG_W),
        .DW (LEN_W),
        .SW (DV_SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r9_v),
        .i_num   (r9_pmag),
        .i_den   (r9_len),
        .i_side  (w_dv_side_in),
        .o_valid (w_dv_v),
        .o_quo   (w_quo),
        .o_side  (w_dv_side_out)
    );

    assign {w_g, w_dv_eneg, w_dv_pneg, w_dv_coinc, w_dv_energy, w_dv_esat} = w_dv_side_out;

    // G * |c| as four partial products; clamp at 2^64 (any nonzero rail then clips)
    assign w_acc = ACC_W'(r11_ll) + (ACC_W'(r11_mid) << LO_W);
    assign w_big = (r11_hh != '0) || (w_acc[ACC_W-1:CAP_W] != '0);

    // stages 10-13: products, magnitude of H, rail scaling
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r10_ll     <= LL_W'(w_g[LO_W-1:0]) * LL_W'(w_quo[LO_W-1:0]);
            r10_lh     <= LH_W'(w_g[LO_W-1:0]) * LH_W'(w_quo[PMAG_W-1:LO_W]);
            r10_hl     <= HL_W'(w_g[G_W-1:LO_W]) * HL_W'(w_quo[LO_W-1:0]);
            r10_hh     <= HH_W'(w_g[G_W-1:LO_W]) * HH_W'(w_quo[PMAG_W-1:LO_W]);
            r10_eneg   <= w_dv_eneg;
            r10_cneg   <= w_dv_pneg && (w_quo != '0);
            r10_coinc  <= w_dv_coinc;
            r10_energy <= w_dv_energy;
            r10_esat   <= w_dv_esat;

            r11_mid    <= MID_W'(r10_lh) + MID_W'(r10_hl);
            r11_ll     <= r10_ll;
            r11_hh     <= r10_hh;
            r11_eneg   <= r10_eneg;
            r11_cneg   <= r10_cneg;
            r11_coinc  <= r10_coinc;
            r11_energy <= r10_energy;
            r11_esat   <= r10_esat;

            r12_hc     <= w_big ? (HC_W'(1) << (HC_W - 1))
                                : HC_W'(w_acc[CAP_W-1:RAIL_FRAC]);
            r12_eneg   <= r11_eneg;
            r12_cneg   <= r11_cneg;
            r12_coinc  <= r11_coinc;
            r12_energy <= r11_energy;
            r12_esat   <= r11_esat;

            for (int i = 0; i < NUM_AXES; i++) begin
                r13_fp[i] <= FP_W'(r12_hc) * FP_W'(w_umag[i]);
            end
            r13_eneg   <= r12_eneg;
            r13_cneg   <= r12_cneg;
            r13_coinc  <= r12_coinc;
            r13_energy <= r12_energy;
            r13_esat   <= r12_esat;
        end
    end

    // per-axis sign, clip and coincident override
    always_comb begin
        w_fsat = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            w_neg[i]  = r13_eneg ^ r13_cneg ^ w_u[i][RAIL_W-1];
            w_fmag[i] = r13_fp[i][FP_W-1:RAIL_FRAC];
            w_over[i] = w_neg[i] ? (w_fmag[i] > FM_W'(FRC_NEG_CAP))
                                 : (w_fmag[i] > FM_W'(FRC_POS_CAP));
            if (r13_coinc) begin
                w_frc[i] = '0;
            end else if (w_over[i]) begin
                w_frc[i] = w_neg[i] ? FRC_NEG_CAP : FRC_POS_CAP;
            end else begin
                w_frc[i] = w_neg[i] ? (FRC_W'(0) - w_fmag[i][FRC_W-1:0])
                                    : w_fmag[i][FRC_W-1:0];
            end
            w_fsat = w_fsat | (w_over[i] & ~r13_coinc);
        end
    end

    // stage 14: output word
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r14_force[i] <= w_frc[i];
            end
            r14_energy <= r13_energy;
            r14_coinc  <= r13_coinc;
            r14_sat    <= r13_esat | w_fsat;
        end
    end

    assign o_valid       = r14_v;
    assign o_force_x     = r14_force[0];
    assign o_force_y     = r14_force[1];
    assign o_force_z     = r14_force[2];
    assign o_bond_energy = r14_energy;
    assign o_coincident  = r14_coinc;
    assign o_saturated   = r14_sat;

endmodule

`default_nettype wire

### design/hbrf_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module hbrf_cfg import hbrf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // always able to take a write
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.k       <= K_RESET;
            r_cfg.r0      <= R0_RESET;
            r_cfg.rail[0] <= RAIL_X_RESET;
            r_cfg.rail[1] <= RAIL_Y_RESET;
            r_cfg.rail[2] <= RAIL_Z_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SPRING: r_cfg.k       <= i_cfg_data[K_W-1:0];
                CFG_REST:   r_cfg.r0      <= i_cfg_data[R0_W-1:0];
                CFG_RAIL_X: r_cfg.rail[0] <= i_cfg_data[RAIL_W-1:0];
                CFG_RAIL_Y: r_cfg.rail[1] <= i_cfg_data[RAIL_W-1:0];
                CFG_RAIL_Z: r_cfg.rail[2] <= i_cfg_data[RAIL_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

### design/hbrf_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root, one result bit per stage.
module hbrf_sqrt #(
    parameter int NW = 66,
    parameter int RW = 33,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_rad,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [RW-1:0] o_root,
    output logic [SW-1:0] o_side
);

    logic [NW-1:0] a_rem  [0:RW];
    logic [RW-1:0] a_root [0:RW];
    logic          a_vld  [0:RW];
    logic [SW-1:0] a_side [0:RW];

    assign a_rem[0]  = i_rad;
    assign a_root[0] = '0;
    assign a_vld[0]  = i_valid;
    assign a_side[0] = i_side;

    generate
        for (genvar gi = 0; gi < RW; gi++) begin : g_stage
            localparam int BIT = RW - 1 - gi;
            logic [NW-1:0] w_trial;
            logic          w_take;
            logic [NW-1:0] r_rem;
            logic [RW-1:0] r_root;
            logic          r_vld;
            logic [SW-1:0] r_side;

            // (root + 2^b)^2 - root^2, root holds only bits above b
            assign w_trial = (NW'(a_root[gi]) << (BIT + 1)) | (NW'(1) << (2 * BIT));
            assign w_take  = (a_rem[gi] >= w_trial);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld <= 1'b0;
                end else if (i_en) begin
                    r_vld <= a_vld[gi];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem  <= w_take ? (a_rem[gi] - w_trial) : a_rem[gi];
                    r_root <= a_root[gi] | (w_take ? (RW'(1) << BIT) : RW'(0));
                    r_side <= a_side[gi];
                end
            end

            assign a_rem[gi+1]  = r_rem;
            assign a_root[gi+1] = r_root;
            assign a_vld[gi+1]  = r_vld;
            assign a_side[gi+1] = r_side;
        end
    endgenerate

    assign o_valid = a_vld[RW];
    assign o_root  = a_root[RW];
    assign o_side  = a_side[RW];

endmodule

`default_nettype wire

### design/hbrf_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, MSB first.
module hbrf_div #(
    parameter int NW = 51,
    parameter int DW = 33,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic [DW-1:0] a_rem  [0:NW];
    logic [NW-1:0] a_num  [0:NW];
    logic [NW-1:0] a_quo  [0:NW];
    logic [DW-1:0] a_den  [0:NW];
    logic          a_vld  [0:NW];
    logic [SW-1:0] a_side [0:NW];

    assign a_rem[0]  = '0;
    assign a_num[0]  = i_num;
    assign a_quo[0]  = '0;
    assign a_den[0]  = i_den;
    assign a_vld[0]  = i_valid;
    assign a_side[0] = i_side;

    generate
        for (genvar gi = 0; gi < NW; gi++) begin : g_stage
            logic [DW:0]   w_shift;
            logic [DW:0]   w_diff;
            logic          w_take;
            logic [DW-1:0] r_rem;
            logic [NW-1:0] r_num;
            logic [NW-1:0] r_quo;
            logic [DW-1:0] r_den;
            logic          r_vld;
            logic [SW-1:0] r_side;

            // bring down the next dividend bit, subtract if it fits
            assign w_shift = {a_rem[gi], a_num[gi][NW-1]};
            assign w_diff  = w_shift - {1'b0, a_den[gi]};
            assign w_take  = (w_shift >= {1'b0, a_den[gi]});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld <= 1'b0;
                end else if (i_en) begin
                    r_vld <= a_vld[gi];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem  <= w_take ? w_diff[DW-1:0] : w_shift[DW-1:0];
                    r_num  <= {a_num[gi][NW-2:0], 1'b0};
                    r_quo  <= {a_quo[gi][NW-2:0], w_take};
                    r_den  <= a_den[gi];
                    r_side <= a_side[gi];
                end
            end

            assign a_rem[gi+1]  = r_rem;
            assign a_num[gi+1]  = r_num;
            assign a_quo[gi+1]  = r_quo;
            assign a_den[gi+1]  = r_den;
            assign a_vld[gi+1]  = r_vld;
            assign a_side[gi+1] = r_side;
        end
    endgenerate

    assign o_valid = a_vld[NW];
    assign o_quo   = a_quo[NW];
    assign o_side  = a_side[NW];

endmodule

`default_nettype wire

### design/hbrf_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module hbrf_chk import hbrf_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic [CRD_W-1:0]      i_first_x,
    input logic [CRD_W-1:0]      i_first_y,
    input logic [CRD_W-1:0]      i_first_z,
    input logic [CRD_W-1:0]      i_second_x,
    input logic [CRD_W-1:0]      i_second_y,
    input logic [CRD_W-1:0]      i_second_z,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [FRC_W-1:0]      o_force_x,
    input logic [FRC_W-1:0]      o_force_y,
    input logic [FRC_W-1:0]      o_force_z,
    input logic [EN_W-1:0]       o_bond_energy,
    input logic                  o_coincident,
    input logic                  o_saturated,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // the pipeline only backs up behind a held output word
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    // coincident atoms carry no force
    a_coinc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_coincident |-> (o_force_x == '0) && (o_force_y == '0)
                                    && (o_force_z == '0))
        else $error("force on coincident atoms");

    // a held output word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_force_x) && $stable(o_force_y)
                               && $stable(o_force_z) && $stable(o_bond_energy)
                               && $stable(o_saturated))
        else $error("held output changed");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind harmonic_bond_rail_force hbrf_chk u_hbrf_chk (.*);

`default_nettype wire

### bench/harmonic_bond_rail_force_checker.sv
`timescale 1ns / 1ps

// Watches the bond, result and register channels of harmonic_bond_rail_force,
// predicts each result word and compares it with what the block delivers.
module harmonic_bond_rail_force_checker import hbrf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  o_stall,
    input  logic [CRD_W-1:0]      i_first_x,
    input  logic [CRD_W-1:0]      i_first_y,
    input  logic [CRD_W-1:0]      i_first_z,
    input  logic [CRD_W-1:0]      i_second_x,
    input  logic [CRD_W-1:0]      i_second_y,
    input  logic [CRD_W-1:0]      i_second_z,
    input  logic                  o_valid,
    input  logic                  i_stall,
    input  logic [FRC_W-1:0]      o_force_x,
    input  logic [FRC_W-1:0]      o_force_y,
    input  logic [FRC_W-1:0]      o_force_z,
    input  logic [EN_W-1:0]       o_bond_energy,
    input  logic                  o_coincident,
    input  logic                  o_saturated,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int SCALE_SHIFT = 16;

    typedef struct {
        logic [FRC_W-1:0] force_x;
        logic [FRC_W-1:0] force_y;
        logic [FRC_W-1:0] force_z;
        logic [EN_W-1:0]  energy;
        logic             coincident;
        logic             saturated;
    } t_bond_force;

    // Shadow copy of the block's registers
    logic [K_W-1:0]           spring_k;
    logic [R0_W-1:0]          rest_len;
    logic signed [RAIL_W-1:0] rail [NUM_AXES];

    t_bond_force expected_forces [$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_forces.size();

    function automatic logic [63:0] abs64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Product of two 64-bit magnitudes shifted down, held at cap
    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b,
                                                   logic [63:0] cap, ref logic clipped);
        logic [127:0] full;
        full = (128'(a) * 128'(b)) >> SCALE_SHIFT;
        if (full > 128'(cap)) begin
            clipped = 1'b1;
            return cap;
        end
        return full[63:0];
    endfunction

    function automatic t_bond_force bond_force_of(logic [CRD_W-1:0] a [NUM_AXES],
                                                  logic [CRD_W-1:0] b [NUM_AXES]);
        t_bond_force  r;
        longint       sep [NUM_AXES];
        longint       rv [NUM_AXES];
        longint       proj, err, cosq, q, d;
        logic [127:0] sum_sq, cand;
        logic [63:0]  len, g, h, f, cap;
        logic [191:0] en_full;
        logic         sat, scratch, neg;
        logic [FRC_W-1:0] comp [NUM_AXES];
        sum_sq  = '0;
        proj    = 0;
        sat     = 1'b0;
        scratch = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            sep[i] = longint'($signed(a[i])) - longint'($signed(b[i]));
            rv[i]  = longint'(rail[i]);
            sum_sq += 128'(abs64(sep[i])) * 128'(abs64(sep[i]));
            proj   += sep[i] * rv[i];
        end
        // Integer square root, one bit at a time
        len = '0;
        for (int bitpos = 34; bitpos >= 0; bitpos--) begin
            cand = 128'(len | (64'd1 << bitpos));
            if (cand * cand <= sum_sq) len = cand[63:0];
        end
        r.coincident = (len == 0);
        for (int i = 0; i < NUM_AXES; i++) comp[i] = '0;
        if (!r.coincident) begin
            err  = longint'(len) - longint'(rest_len);
            cosq = proj / longint'(len);
            g = scaled_product(64'(spring_k), abs64(err), '1, scratch);
            h = scaled_product(g, abs64(cosq), '1, scratch);
            for (int i = 0; i < NUM_AXES; i++) begin
                neg = ((err < 0) != (cosq < 0)) != (rv[i] < 0);
                cap = neg ? 64'(FRC_NEG_CAP) : 64'(FRC_POS_CAP);
                f = scaled_product(h, abs64(rv[i]), cap, sat);
                comp[i] = neg ? FRC_W'(-f) : FRC_W'(f);
            end
        end
        r.force_x = comp[0];
        r.force_y = comp[1];
        r.force_z = comp[2];
        // Energy along the rail
        q = proj / (longint'(1) << RAIL_FRAC);
        d = q - longint'(rest_len);
        en_full = (192'(abs64(d)) * 192'(abs64(d)) * 192'(spring_k)) >> 33;
        if (en_full > 192'({EN_W{1'b1}})) begin
            sat      = 1'b1;
            r.energy = '1;
        end else begin
            r.energy = en_full[EN_W-1:0];
        end
        r.saturated = sat;
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        logic [CRD_W-1:0] a [NUM_AXES];
        logic [CRD_W-1:0] b [NUM_AXES];
        t_bond_force      exp_w;
        if (!i_rst_n) begin
            spring_k   <= K_RESET;
            rest_len   <= R0_RESET;
            rail[0]    <= RAIL_X_RESET;
            rail[1]    <= RAIL_Y_RESET;
            rail[2]    <= RAIL_Z_RESET;
            fail_count = 0;
            expected_forces.delete();
        end else begin
            // Register writes; out-of-range indexes are dropped
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SPRING: spring_k <= i_cfg_data;
                    CFG_REST:   rest_len <= i_cfg_data;
                    CFG_RAIL_X: rail[0]  <= i_cfg_data[RAIL_W-1:0];
                    CFG_RAIL_Y: rail[1]  <= i_cfg_data[RAIL_W-1:0];
                    CFG_RAIL_Z: rail[2]  <= i_cfg_data[RAIL_W-1:0];
                    default: ;
                endcase
            end
            // Accepted bond word
            if (i_valid && !o_stall) begin
                a = '{i_first_x, i_first_y, i_first_z};
                b = '{i_second_x, i_second_y, i_second_z};
                expected_forces.push_back(bond_force_of(a, b));
            end
            // Accepted result word
            if (o_valid && !i_stall) begin
                if (expected_forces.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    exp_w = expected_forces.pop_front();
                    check_field("force_x", 64'(exp_w.force_x), 64'(o_force_x));
                    check_field("force_y", 64'(exp_w.force_y), 64'(o_force_y));
                    check_field("force_z", 64'(exp_w.force_z), 64'(o_force_z));
                    check_field("bond_energy", 64'(exp_w.energy), 64'(o_bond_energy));
                    check_field("coincident", 64'(exp_w.coincident), 64'(o_coincident));
                    check_field("saturated", 64'(exp_w.saturated), 64'(o_saturated));
                end
            end
        end
    end

endmodule

### bench/harmonic_bond_rail_force_test.sv
`timescale 1ns / 1ps

module harmonic_bond_rail_force_test;
    import hbrf_pkg::*;

    localparam int LATENCY     = 98;
    localparam int IDLE_PCT    = 19;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD   = 400;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 200;
    localparam logic [RAIL_W-1:0] RAIL_ONE = 18'h1_0000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [CRD_W-1:0]      i_first_x = '0, i_first_y = '0, i_first_z = '0;
    logic [CRD_W-1:0]      i_second_x = '0, i_second_y = '0, i_second_z = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [FRC_W-1:0]      o_force_x, o_force_y, o_force_z;
    logic [EN_W-1:0]       o_bond_energy;
    logic                  o_coincident, o_saturated;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int   fail_count, pending;
    bit   quiet = 1'b0;
    bit   hold_request = 1'b0;
    int   idle_cycles = 0;

    always #2 i_clk = ~i_clk;

    harmonic_bond_rail_force uut (.*);

    harmonic_bond_rail_force_checker checker_i (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result receiver: random stalls plus one long hold on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        #1;
        while (!o_cfg_ready) begin
            @(negedge i_clk);
            #1;
        end
        @(posedge i_clk);
    endtask

    task automatic load_settings(logic [31:0] k, logic [31:0] r0,
                                 logic [RAIL_W-1:0] ux, logic [RAIL_W-1:0] uy,
                                 logic [RAIL_W-1:0] uz);
        write_reg(CFG_SPRING, k);
        write_reg(CFG_REST, r0);
        write_reg(CFG_RAIL_X, {$urandom} << RAIL_W | 32'(ux));
        write_reg(CFG_RAIL_Y, 32'(uy));
        write_reg(CFG_RAIL_Z, 32'(uz));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_bond(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                             logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_first_x  <= ax;
        i_first_y  <= ay;
        i_first_z  <= az;
        i_second_x <= bx;
        i_second_y <= by;
        i_second_z <= bz;
        #1;
        while (o_stall) begin
            @(negedge i_clk);
            #1;
        end
        @(posedge i_clk);
    endtask

    // Coordinate scaled down by a random shift, so most bonds stay short
    function automatic logic [31:0] rand_coord();
        return 32'($signed($urandom) >>> $urandom_range(0, 31));
    endfunction

    task automatic send_random_bond();
        logic [31:0] a [3];
        logic [31:0] b [3];
        int          mode;
        mode = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++) begin
            a[i] = (mode < 15) ? $urandom : rand_coord();
            if (mode < 15)      b[i] = $urandom;
            else if (mode < 25) b[i] = a[i];
            else if (mode < 65) b[i] = a[i] - rand_coord();
            else                b[i] = rand_coord();
        end
        send_bond(a[0], a[1], a[2], b[0], b[1], b[2]);
    endtask

    // Stop offering words, then wait for every result to come back
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [RAIL_W-1:0] rand_rail();
        return RAIL_W'($urandom_range(0, 131072) - 65536);
    endfunction

    initial begin
        logic [31:0] k, r0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bonds at reset settings
        send_bond(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_bond(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_bond('0, '0, '0, '0, '0, '0);
        send_bond(32'h1234_5678, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h1234_5678, 32'h8000_0000, 32'hFFFF_FFFF);
        send_bond(32'h0001_0000, '0, '0, '0, '0, '0);
        send_bond('0, '0, '0, 32'h0001_0000, '0, '0);
        send_bond(32'h0002_0000, 32'h0003_0000, '0, '0, '0, '0);
        send_bond('0, 32'h0005_0000, '0, '0, '0, '0);
        send_bond(32'h0000_0001, '0, '0, '0, '0, '0);
        send_bond(32'h7FFF_FFFF, '0, '0, 32'h8000_0000, '0, '0);
        send_bond(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0);
        drain();

        // Saturation: largest k and r0, negative rail; unused indexes ignored
        load_settings('1, '1, -RAIL_ONE, '0, '0);
        for (int idx = CFG_RAIL_Z + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), $urandom);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        send_bond(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_bond('0, '0, '0, '0, '0, '0);
        send_bond(32'h0010_0000, 32'h0010_0000, '0, '0, '0, '0);
        send_bond(32'h8000_0000, '0, '0, 32'h7FFF_FFFF, '0, '0);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            k  = $urandom >> $urandom_range(0, 31);
            r0 = $urandom >> $urandom_range(0, 31);
            case (ph)
                0: load_settings('1, '1, -RAIL_ONE, RAIL_ONE, '0);
                1: load_settings('0, 32'd1, '0, RAIL_ONE, '0);
                2: load_settings(k, r0, '0, '0, -RAIL_ONE);
                3: load_settings($urandom, '0, 18'h1_FFFF, 18'h2_0000, RAIL_W'($urandom));
                default: load_settings(k, r0, rand_rail(), rand_rail(), rand_rail());
            endcase
            quiet = (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Back up the pipeline with a long result hold
                if (ph == 2 && n == 20) hold_request = 1'b1;
                // Let the block empty out before carrying on
                if (ph == 4 && n == PHASE_ITEMS / 2) begin
                    @(negedge i_clk);
                    i_valid <= 1'b0;
                    while (pending != 0) @(posedge i_clk);
                end
                send_random_bond();
            end
            quiet = 1'b0;
            drain();
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
